### rtl/core/rdwr_pkg.sv
// Package for the random draw without replacement block.
// Holds the sizes, request and result types, status codes and state encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdwr_pkg;

  localparam int POOL_DEPTH   = 1024;
  localparam int RANDOM_WIDTH = 31;
  localparam int IDX_W        = $clog2(POOL_DEPTH);
  localparam int CNT_W        = $clog2(POOL_DEPTH + 1);
  localparam int SHIFT_W      = IDX_W + 1;
  localparam int STEP_W       = $clog2(RANDOM_WIDTH + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERSIZE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_START,
    ST_DIVIDE,
    ST_READ_POS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                    kind;
    logic [CNT_W-1:0]        pool_size;
    logic [RANDOM_WIDTH-1:0] random_word;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] drawn_index;
    status_t          status;
    logic [CNT_W-1:0] remaining;
  } rsp_t;

  typedef struct packed {
    logic                    start;
    logic [RANDOM_WIDTH-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/rdwr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rdwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/rdwr_divmod.sv
// Bit-serial restoring remainder unit: random word modulo the live count.
// Depends on rdwr_pkg for widths and the request and result structs.
`timescale 1ns / 1ps
`default_nettype none

module rdwr_divmod (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rdwr_pkg::div_req_t req,
  output      rdwr_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [rdwr_pkg::STEP_W-1:0]       steps;
  logic [rdwr_pkg::RANDOM_WIDTH-1:0] quo;
  logic [rdwr_pkg::IDX_W-1:0]        rem;
  logic [rdwr_pkg::CNT_W-1:0]        divisor;
  logic [rdwr_pkg::SHIFT_W-1:0]      shifted;
  logic [rdwr_pkg::SHIFT_W-1:0]      divisor_ext;
  logic [rdwr_pkg::SHIFT_W-1:0]      diff;

  always_comb begin
    shifted     = {rem, quo[rdwr_pkg::RANDOM_WIDTH-1]};
    divisor_ext = rdwr_pkg::SHIFT_W'(divisor);
    diff        = shifted - divisor_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (steps == rdwr_pkg::STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (steps == rdwr_pkg::STEP_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      steps   <= rdwr_pkg::STEP_W'(rdwr_pkg::RANDOM_WIDTH);
      quo     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      steps <= steps - rdwr_pkg::STEP_W'(1);
      quo   <= {quo[rdwr_pkg::RANDOM_WIDTH-2:0], 1'b0};
      if (shifted >= divisor_ext) begin
        rem <= diff[rdwr_pkg::IDX_W-1:0];
      end else begin
        rem <= shifted[rdwr_pkg::IDX_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

### rtl/core/random_draw_without_replacement.sv
// Top level of the random draw without replacement block.
// Depends on rdwr_pkg, rdwr_ram and rdwr_divmod.
//
// Requests arrive on req_valid / req_stall / req_data and results leave on
// rsp_valid / rsp_stall / rsp_data, one result per request. A request is
// taken at a clock edge with valid high and stall low.
// A refill request (kind 1) first writes the identities 0..pool_size-1 into
// the pool memory, one entry per cycle, then draws. A draw reduces the random
// word modulo the live count in a bit-serial unit, one bit per cycle, then
// reads the chosen entry and writes the last live entry into its place.
// An oversized refill goes straight to the finish state, and a draw from an
// empty pool passes from the start state to the finish state. The next
// request can be taken in the cycle after a result is loaded.
// One request is in flight at a time: req_stall is high from acceptance until
// the result moves into the output register. A result held by rsp_stall stays
// in that register; the next request is still accepted and runs up to its
// result, where it waits for the register to empty.
// Synchronous reset empties the pool and the output register.
`timescale 1ns / 1ps
`default_nettype none

module random_draw_without_replacement (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output      logic           req_stall,
  input  wire rdwr_pkg::req_t req_data,
  output      logic           rsp_valid,
  input  wire logic           rsp_stall,
  output      rdwr_pkg::rsp_t rsp_data
);

  rdwr_pkg::state_t                  state;
  rdwr_pkg::state_t                  state_next;
  logic [rdwr_pkg::CNT_W-1:0]        live;
  logic [rdwr_pkg::CNT_W-1:0]        fill_idx;
  logic [rdwr_pkg::CNT_W-1:0]        size;
  logic [rdwr_pkg::RANDOM_WIDTH-1:0] rnd;
  logic [rdwr_pkg::IDX_W-1:0]        last_entry;
  logic [rdwr_pkg::IDX_W-1:0]        pos;
  rdwr_pkg::rsp_t                    result;

  logic                              accept;
  logic                              oversize;
  logic                              out_free;
  logic [rdwr_pkg::CNT_W-1:0]        live_dec;
  logic                              fill_last;

  logic                              ram_we;
  logic [rdwr_pkg::IDX_W-1:0]        ram_waddr;
  logic [rdwr_pkg::IDX_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [rdwr_pkg::IDX_W-1:0]        ram_raddr;
  logic [rdwr_pkg::IDX_W-1:0]        ram_rdata;

  rdwr_pkg::div_req_t                div_req;
  rdwr_pkg::div_rsp_t                div_rsp;

  assign accept    = req_valid && !req_stall;
  assign oversize  = req_data.pool_size > rdwr_pkg::CNT_W'(rdwr_pkg::POOL_DEPTH);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign live_dec  = live - rdwr_pkg::CNT_W'(1);
  assign fill_last = (fill_idx + rdwr_pkg::CNT_W'(1)) == size;
  assign req_stall = (state != rdwr_pkg::ST_IDLE);

  rdwr_ram #(
    .WIDTH(rdwr_pkg::IDX_W),
    .DEPTH(rdwr_pkg::POOL_DEPTH)
  ) u_pool (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rdwr_divmod u_divmod (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rdwr_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_data.kind && oversize) begin
            state_next = rdwr_pkg::ST_FINISH;
          end else if (req_data.kind && (req_data.pool_size != '0)) begin
            state_next = rdwr_pkg::ST_FILL;
          end else begin
            state_next = rdwr_pkg::ST_START;
          end
        end
      end
      rdwr_pkg::ST_FILL: begin
        if (fill_last) begin
          state_next = rdwr_pkg::ST_START;
        end
      end
      rdwr_pkg::ST_START: begin
        if (live == '0) begin
          state_next = rdwr_pkg::ST_FINISH;
        end else begin
          state_next = rdwr_pkg::ST_DIVIDE;
        end
      end
      rdwr_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = rdwr_pkg::ST_READ_POS;
        end
      end
      rdwr_pkg::ST_READ_POS: begin
        state_next = rdwr_pkg::ST_FINISH;
      end
      rdwr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = rdwr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdwr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = fill_idx[rdwr_pkg::IDX_W-1:0];
    ram_wdata        = fill_idx[rdwr_pkg::IDX_W-1:0];
    ram_re           = 1'b0;
    ram_raddr        = live_dec[rdwr_pkg::IDX_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = rnd;
    div_req.divisor  = live;
    unique case (state)
      rdwr_pkg::ST_FILL: begin
        ram_we = 1'b1;
      end
      rdwr_pkg::ST_START: begin
        ram_re        = (live != '0);
        div_req.start = (live != '0);
      end
      rdwr_pkg::ST_DIVIDE: begin
        ram_re    = div_rsp.done;
        ram_raddr = div_rsp.rem;
      end
      rdwr_pkg::ST_READ_POS: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = last_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdwr_pkg::ST_IDLE;
      live      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req_data.kind && !oversize) begin
        live <= req_data.pool_size;
      end else if (state == rdwr_pkg::ST_READ_POS) begin
        live <= live_dec;
      end
      if ((state == rdwr_pkg::ST_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      size     <= req_data.pool_size;
      rnd      <= req_data.random_word;
      fill_idx <= '0;
      if (req_data.kind && oversize) begin
        result.drawn_index <= '0;
        result.status      <= rdwr_pkg::STATUS_OVERSIZE;
        result.remaining   <= live;
      end
    end
    if (state == rdwr_pkg::ST_FILL) begin
      fill_idx <= fill_idx + rdwr_pkg::CNT_W'(1);
    end
    if ((state == rdwr_pkg::ST_START) && (live == '0)) begin
      result.drawn_index <= '0;
      result.status      <= rdwr_pkg::STATUS_EMPTY;
      result.remaining   <= '0;
    end
    if ((state == rdwr_pkg::ST_DIVIDE) && div_rsp.done) begin
      last_entry <= ram_rdata;
      pos        <= div_rsp.rem;
    end
    if (state == rdwr_pkg::ST_READ_POS) begin
      result.drawn_index <= ram_rdata;
      result.status      <= rdwr_pkg::STATUS_OK;
      result.remaining   <= live_dec;
    end
    if ((state == rdwr_pkg::ST_FINISH) && out_free) begin
      rsp_data <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rdwr_checker.sv
// Port-level checker for random_draw_without_replacement, bound to the top level.
// Depends on rdwr_pkg for the result type and status codes.
`timescale 1ns / 1ps
`default_nettype none

module rdwr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire rdwr_pkg::rsp_t rsp_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  a_failed_draw_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status == rdwr_pkg::STATUS_OK) || (rsp_data.drawn_index == '0))
    else $error("nonzero index on a failed draw");

  a_empty_remaining: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == rdwr_pkg::STATUS_EMPTY) |-> (rsp_data.remaining == '0))
    else $error("empty pool reported with entries left");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in flight");

endmodule

bind random_draw_without_replacement rdwr_checker u_rdwr_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp_data (rsp_data)
);

`default_nettype wire
